// ===== sv/smeu_pkg.sv =====
// Package: shared types, opcodes and status codes of the stack-machine execute unit.
`timescale 1ns / 1ps
package smeu_pkg;
    localparam int unsigned StackDepthDef = 64;
    localparam int unsigned ProgramMaxDef = 1024;
    localparam int unsigned WordW = 32;
    localparam int unsigned CfgW = 11;
    localparam int unsigned IpOutW = 10;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0, OP_POP = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
        OP_MUL = 4'd4, OP_DIV = 4'd5, OP_HALT = 4'd6, OP_PRINT = 4'd7,
        OP_JMP = 4'd8, OP_JZ = 4'd9, OP_JNZ = 4'd10, OP_JE = 4'd11,
        OP_JNE = 4'd12, OP_JGE = 4'd13, OP_JLE = 4'd14, OP_NOP = 4'd15
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALT = 3'd1, ST_IGNORED = 3'd2, ST_IP_OOB = 3'd3,
        ST_DIV0 = 3'd4, ST_UNDER = 3'd5, ST_OVER = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_TOP, S_OUT
    } state_t;

    // request to the divider and its answer
    typedef struct packed {
        logic start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [WordW-1:0] quotient;
    } div_rsp_t;
endpackage

// ===== sv/smeu_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module smeu_div
    import smeu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [WordW-1:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [WordW:0] trial;

    always_comb begin
        rem_next = rem_reg; quo_next = quo_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; neg_next = neg_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[WordW-1]} - {1'b0, dvs_reg};
        if (req.start) begin
            rem_next = '0;
            quo_next = req.dividend[WordW-1] ? -req.dividend : req.dividend;
            dvs_next = req.divisor[WordW-1] ? -req.divisor : req.divisor;
            neg_next = req.dividend[WordW-1] ^ req.divisor[WordW-1];
            cnt_next = 6'(WordW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[WordW]) begin
                rem_next = trial[WordW-1:0];
            end else begin
                rem_next = {rem_reg[WordW-2:0], quo_reg[WordW-1]};
            end
            quo_next = {quo_reg[WordW-2:0], ~trial[WordW]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next; quo_reg <= quo_next; dvs_reg <= dvs_next;
        cnt_reg <= cnt_next; neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = neg_reg ? -quo_reg : quo_reg;
endmodule

// ===== sv/stack_machine_execute_unit.sv =====
// Top level: stack-machine execute unit around a one-port-read stack memory.
// A request passes the states read, execute, top read and out before its result is offered;
// mul adds a multiply state, div a divide state (one quotient bit per cycle). One request at a time.
// A new request is taken only when the unit is idle and the last result has been accepted.
// Reset (aresetn low, synchronous): empty stack, ip 0, running, program_length 1024.
// Stack memory contents are not cleared; only entries below the count are used.
`timescale 1ns / 1ps
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = StackDepthDef,
    parameter int unsigned PROGRAM_MAX = ProgramMaxDef
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [39:0]     s_tdata,   // [3:0] op, [35:4] operand, rest zero
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [47:0]     m_tdata,   // [9:0] next_ip, [41:10] top_value, [42] top_valid,
                                       // [43] print_strobe, [46:44] status, [47] stopped
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CfgW-1:0] cfg_data
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;

    logic [CfgW-1:0]  plen_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WordW-1:0] ip_reg, ip_next;   // full width so far jumps stay out of bounds
    logic             run_reg, run_next;

    logic [3:0]       op_reg;
    logic [WordW-1:0] imm_reg;
    logic [WordW-1:0] a_reg, a_next;     // second from top, latched from memory
    logic [WordW-1:0] res_reg, res_next; // value to push
    logic [2:0]       st_reg, st_next;
    logic             strobe_reg, strobe_next;
    logic [47:0]      out_reg;
    logic             outv_reg;

    // stack memory, one write and one registered read per cycle
    logic [WordW-1:0] stack_mem [STACK_DEPTH];
    logic [WordW-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en;

    logic [WordW-1:0] mul_reg;
    div_req_t         dreq;
    div_rsp_t         drsp;

    logic [WordW-1:0] b_val;
    logic [1:0]       need;
    logic [WordW-1:0] eff_len;
    logic             ip_oob;

    smeu_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign s_tready  = (state_reg == S_IDLE) && !outv_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = outv_reg;
    assign m_tdata   = out_reg;

    assign eff_len = (WordW'(plen_reg) > WordW'(PROGRAM_MAX)) ? WordW'(PROGRAM_MAX)
                                                              : WordW'(plen_reg);
    assign ip_oob  = ip_reg >= eff_len;
    assign b_val   = rd_data_reg;

    always_comb begin
        unique case (op_t'(op_reg))
            OP_POP, OP_PRINT, OP_JZ, OP_JNZ: need = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_JE, OP_JNE, OP_JGE, OP_JLE:   need = 2'd2;
            default:                         need = 2'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC: begin
                if (!run_reg || ip_oob || (cnt_reg < CW'(need))) begin
                    state_next = S_TOP;
                end else if (op_t'(op_reg) == OP_MUL) begin
                    state_next = S_MUL;
                end else if (op_t'(op_reg) == OP_DIV && b_val != '0) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_TOP;
                end
            end
            S_MUL: state_next = S_TOP;
            S_DIV: if (drsp.done) state_next = S_TOP;
            S_TOP: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next = cnt_reg; ip_next = ip_reg; run_next = run_reg;
        a_next = a_reg; res_next = res_reg; st_next = st_reg; strobe_next = strobe_reg;
        rd_addr = AW'(cnt_reg - CW'(1));
        wr_en = 1'b0; wr_addr = AW'(cnt_reg); dreq = '0;
        unique case (state_reg)
            S_IDLE: begin
                st_next = ST_OK; strobe_next = 1'b0;
                rd_addr = AW'(cnt_reg - CW'(2));
            end
            S_READ: begin
                a_next = rd_data_reg;
                rd_addr = AW'(cnt_reg - CW'(1));
            end
            S_EXEC: begin
                if (!run_reg) begin
                    st_next = ST_IGNORED;
                end else if (ip_oob) begin
                    st_next = ST_IP_OOB; run_next = 1'b0;
                end else if (cnt_reg < CW'(need)) begin
                    st_next = ST_UNDER; run_next = 1'b0; ip_next = ip_reg + 1;
                end else begin
                    ip_next = ip_reg + 1;
                    unique case (op_t'(op_reg))
                        OP_PUSH: begin
                            if (cnt_reg >= CW'(STACK_DEPTH)) begin
                                st_next = ST_OVER; run_next = 1'b0;
                            end else begin
                                wr_en = 1'b1; wr_addr = AW'(cnt_reg);
                                res_next = imm_reg; cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_POP: cnt_next = cnt_reg - CW'(1);
                        OP_ADD, OP_SUB: begin
                            res_next = (op_t'(op_reg) == OP_ADD) ? a_reg + b_val
                                                                 : a_reg - b_val;
                            wr_en = 1'b1; wr_addr = AW'(cnt_reg - CW'(2));
                            cnt_next = cnt_reg - CW'(1);
                        end
                        OP_MUL: cnt_next = cnt_reg - CW'(2);
                        OP_DIV: begin
                            cnt_next = cnt_reg - CW'(2);
                            if (b_val == '0) begin
                                st_next = ST_DIV0; run_next = 1'b0;
                            end else begin
                                dreq.start = 1'b1;
                                dreq.dividend = a_reg; dreq.divisor = b_val;
                            end
                        end
                        OP_HALT: begin
                            st_next = ST_HALT; run_next = 1'b0;
                        end
                        OP_PRINT: strobe_next = 1'b1;
                        OP_JMP: ip_next = imm_reg;
                        OP_JZ, OP_JNZ: begin
                            cnt_next = cnt_reg - CW'(1);
                            if ((b_val == '0) == (op_t'(op_reg) == OP_JZ)) ip_next = imm_reg;
                        end
                        OP_JE, OP_JNE, OP_JGE, OP_JLE: begin
                            cnt_next = cnt_reg - CW'(2);
                            priority case (op_t'(op_reg))
                                OP_JE:  if (a_reg == b_val) ip_next = imm_reg;
                                OP_JNE: if (a_reg != b_val) ip_next = imm_reg;
                                OP_JGE: if ($signed(a_reg) >= $signed(b_val))
                                            ip_next = imm_reg;
                                default: if ($signed(a_reg) <= $signed(b_val))
                                            ip_next = imm_reg;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                wr_en = 1'b1; wr_addr = AW'(cnt_reg); cnt_next = cnt_reg + CW'(1);
            end
            S_DIV: begin
                if (drsp.done) begin
                    wr_en = 1'b1; wr_addr = AW'(cnt_reg); cnt_next = cnt_reg + CW'(1);
                end
            end
            S_TOP: rd_addr = AW'(cnt_reg - CW'(1));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (state_reg == S_MUL) stack_mem[wr_addr] <= mul_reg;
            else if (state_reg == S_DIV) stack_mem[wr_addr] <= drsp.quotient;
            else stack_mem[wr_addr] <= res_next;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            plen_reg  <= CfgW'(1024);
            cnt_reg   <= '0;
            ip_reg    <= '0;
            run_reg   <= 1'b1;
            outv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ip_reg    <= ip_next;
            run_reg   <= run_next;
            if (cfg_valid && cfg_ready) plen_reg <= cfg_data;
            if (state_reg == S_OUT) outv_reg <= 1'b1;
            else if (m_tready) outv_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[3:0];
            imm_reg <= s_tdata[35:4];
        end
        a_reg <= a_next; res_reg <= res_next; st_reg <= st_next; strobe_reg <= strobe_next;
        mul_reg <= a_reg * b_val;
        if (state_reg == S_OUT) begin
            out_reg <= {!run_reg, st_reg, strobe_reg, (cnt_reg != '0),
                        ((cnt_reg != '0) ? rd_data_reg : WordW'(0)),
                        ip_reg[IpOutW-1:0]};
        end
    end
endmodule

// ===== verif/stack_machine_execute_unit_tb.sv =====
// Testbench: directed and random instruction streams, checked against a stack-machine predictor.
`timescale 1ns / 1ps
module stack_machine_execute_unit_tb;
    import smeu_pkg::*;

    localparam int unsigned DEPTH = StackDepthDef;
    localparam int unsigned PMAX = ProgramMaxDef;
    localparam int unsigned WDOG_LIMIT = 20000;

    // One result as it sits in m_tdata, msb first.
    typedef struct packed {
        logic          stopped;
        status_t       status;
        logic          strobe;
        logic          top_ok;
        logic [31:0]   top;
        logic [9:0]    nip;
    } vm_res_t;

    typedef struct {
        op_t         op;
        logic [31:0] arg;
        bit          typed;
        vm_res_t     res;
    } vm_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [3:0] op, [35:4] operand, rest zero
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;          // [9:0] next_ip, [41:10] top_value, [42] top_valid,
                                   // [43] print_strobe, [46:44] status, [47] stopped
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    stack_machine_execute_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [31:0] vm_stack [DEPTH];
    int unsigned vm_count = 0;
    logic [31:0] vm_ip = '0;
    bit          vm_running = 1;
    logic [10:0] vm_plen = 11'd1024;

    vm_res_t     expected_q[$];
    vm_row_t     dir_rows[$];
    int          errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_no = 0;

    function automatic int unsigned eff_len();
        return (vm_plen < PMAX) ? vm_plen : PMAX;
    endfunction

    function automatic int unsigned need_of(op_t op);
        case (op)
            OP_POP, OP_PRINT, OP_JZ, OP_JNZ: return 1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JE, OP_JNE, OP_JGE, OP_JLE: return 2;
            default: return 0;
        endcase
    endfunction

    // Execute one instruction on the predictor state; returns the expected result.
    function automatic vm_res_t exec_instr(op_t op, logic [31:0] arg);
        vm_res_t r;
        logic [31:0] a, b, q;
        longint sa, sb;
        bit jump;
        status_t st;
        a = '0; b = '0; jump = 0; st = ST_OK;
        r = '0;
        if (!vm_running) begin
            st = ST_IGNORED;
        end else if (vm_ip >= eff_len()) begin
            st = ST_IP_OOB;
            vm_running = 0;
        end else if (vm_count < need_of(op)) begin
            st = ST_UNDER;
            vm_running = 0;
            vm_ip = vm_ip + 1;
        end else begin
            if (need_of(op) >= 1) b = vm_stack[vm_count-1];
            if (need_of(op) == 2) a = vm_stack[vm_count-2];
            sa = $signed(a);
            sb = $signed(b);
            case (op)
                OP_PUSH: begin
                    if (vm_count >= DEPTH) begin
                        st = ST_OVER;
                        vm_running = 0;
                    end else begin
                        vm_stack[vm_count] = arg;
                        vm_count++;
                    end
                end
                OP_POP: vm_count--;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    vm_count -= 2;
                    if (op == OP_DIV && b == 0) begin
                        st = ST_DIV0;
                        vm_running = 0;
                    end else begin
                        case (op)
                            OP_ADD: q = a + b;
                            OP_SUB: q = a - b;
                            OP_MUL: q = a * b;
                            default: q = 32'(sa / sb);   // truncates, min/-1 wraps
                        endcase
                        vm_stack[vm_count] = q;
                        vm_count++;
                    end
                end
                OP_HALT: begin
                    st = ST_HALT;
                    vm_running = 0;
                end
                OP_PRINT: r.strobe = 1;
                OP_JMP: jump = 1;
                OP_JZ, OP_JNZ: begin
                    vm_count--;
                    jump = (op == OP_JZ) ? (b == 0) : (b != 0);
                end
                OP_JE, OP_JNE, OP_JGE, OP_JLE: begin
                    vm_count -= 2;
                    case (op)
                        OP_JE:   jump = (sa == sb);
                        OP_JNE:  jump = (sa != sb);
                        OP_JGE:  jump = (sa >= sb);
                        default: jump = (sa <= sb);
                    endcase
                end
                default: ;
            endcase
            vm_ip = jump ? arg : vm_ip + 1;
        end
        r.nip = vm_ip[9:0];
        r.top_ok = (vm_count > 0);
        r.top = (vm_count > 0) ? vm_stack[vm_count-1] : '0;
        r.status = st;
        r.stopped = !vm_running;
        return r;
    endfunction

    function automatic vm_res_t mk_res(int nip, logic [31:0] top, bit ok, bit strobe);
        vm_res_t r;
        r.nip = nip[9:0];
        r.top = top;
        r.top_ok = ok;
        r.strobe = strobe;
        r.status = ST_OK;
        r.stopped = 0;
        return r;
    endfunction

    task automatic add_row(op_t op, logic [31:0] arg, bit typed = 0, vm_res_t res = '0);
        vm_row_t row;
        row.op = op;
        row.arg = arg;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Sender: bursts of random length, random gaps between them.
    task automatic send_request(op_t op, logic [31:0] arg, bit typed, vm_res_t res);
        int unsigned gap;
        vm_res_t p;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, arg, op};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        p = exec_instr(op, arg);
        expected_q.push_back(typed ? res : p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge aclk);   // div path is the slowest
    endtask

    task automatic write_length(logic [10:0] len);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vm_plen = len;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4, 5: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Random well-formed instruction: never stops the machine.
    task automatic send_random();
        op_t op;
        logic [31:0] arg;
        int unsigned len;
        len = eff_len();
        op = op_t'($urandom_range(0, 15));
        arg = rand_word();
        if (op == OP_HALT) op = OP_NOP;
        if (vm_count < need_of(op) || (op == OP_PUSH && vm_count >= DEPTH)
            || (op == OP_DIV && vm_stack[vm_count-1] == 0))
            op = (vm_count < DEPTH) ? OP_PUSH : OP_POP;
        if (vm_ip + 1 >= len) op = OP_JMP;
        if (op >= OP_JMP && op <= OP_JLE) arg = $urandom_range(0, len - 1);
        send_request(op, arg, 0, '0);
    endtask

    // Receiver: own stall pattern, plus long hold-offs to back up the input.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if ((cycle_no % 5000) > 3000 && (cycle_no % 5000) < 3300) begin
            m_tready <= 1'b0;
        end else if (cycle_no[7]) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result check and watchdog.
    always @(posedge aclk) begin
        vm_res_t got, want;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL stack_machine_execute_unit");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = vm_res_t'(m_tdata);
            if (expected_q.size() == 0) begin
                report("unexpected result", m_tdata, '0);
            end else begin
                want = expected_q.pop_front();
                if (got.nip != want.nip) report("next_ip", got, want);
                if (got.top != want.top) report("top_value", got, want);
                if (got.top_ok != want.top_ok) report("top_valid", got, want);
                if (got.strobe != want.strobe) report("print_strobe", got, want);
                if (got.status != want.status) report("status", got, want);
                if (got.stopped != want.stopped) report("stopped", got, want);
            end
        end
    end

    initial begin
        logic [10:0] lengths [5];
        lengths = '{11'd2047, 11'd1, 11'd2, 11'd37, 11'd1024};

        // directed program: wrap cases, every jump, taken and not taken
        add_row(OP_PUSH, 32'h7fff_ffff, 1, mk_res(1, 32'h7fff_ffff, 1, 0));
        add_row(OP_PUSH, 32'd1);
        add_row(OP_ADD, 32'd0, 1, mk_res(3, 32'h8000_0000, 1, 0));   // add wraps
        add_row(OP_PUSH, 32'hffff_ffff);
        add_row(OP_DIV, 32'd0, 1, mk_res(5, 32'h8000_0000, 1, 0));   // min / -1
        add_row(OP_PUSH, 32'd3);
        add_row(OP_MUL, 32'd0);
        add_row(OP_PRINT, 32'd0, 1, mk_res(8, 32'h8000_0000, 1, 1));
        add_row(OP_PUSH, -32'sd7);
        add_row(OP_PUSH, 32'd2);
        add_row(OP_DIV, 32'd0);                                      // truncates to -3
        add_row(OP_SUB, 32'd0);
        add_row(OP_PUSH, 32'd0);
        add_row(OP_JZ, 32'd20);
        add_row(OP_JNZ, 32'd25, 1, mk_res(25, 32'd0, 0, 0));
        add_row(OP_PUSH, 32'd5);
        add_row(OP_PUSH, 32'd5);
        add_row(OP_JE, 32'd40);
        add_row(OP_PUSH, 32'd1);
        add_row(OP_PUSH, 32'd2);
        add_row(OP_JNE, 32'd50);
        add_row(OP_PUSH, 32'hffff_ffff);
        add_row(OP_PUSH, 32'd1);
        add_row(OP_JGE, 32'd60);                                     // not taken
        add_row(OP_PUSH, 32'd4);
        add_row(OP_PUSH, 32'd4);
        add_row(OP_JLE, 32'd70);
        add_row(OP_PUSH, 32'd9);
        add_row(OP_POP, 32'd0);
        add_row(OP_NOP, 32'd0);
        add_row(OP_JMP, 32'd0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].arg, dir_rows[i].typed, dir_rows[i].res);

        // random phases, each ends back at ip 0 so any length is safe to write
        for (int ph = 0; ph < 6; ph++) begin
            repeat ((ph == 2 || ph == 3) ? 150 : 300) send_random();
            send_request(OP_JMP, 32'd0, 0, '0);
            if (ph < 5) begin
                wait_idle();
                write_length(lengths[ph]);
            end
        end

        // negative jump target leaves the program; then length 0 and stopped machine
        send_request(OP_JMP, 32'hffff_ffff, 0, '0);
        wait_idle();
        write_length(11'd0);
        send_request(OP_HALT, 32'd0, 0, '0);
        repeat (30) begin
            send_request(op_t'($urandom_range(0, 15)), $urandom, 0, '0);
        end
        wait_idle();

        if (errors == 0) begin
            $display("PASS stack_machine_execute_unit");
        end else begin
            $display("FAIL stack_machine_execute_unit");
        end
        $finish;
    end
endmodule
